### design/olir_pkg.sv
// Ordered list insert/remove: shared constants, codes and types.
// No dependencies; every other design file uses this package.
package olir_pkg;

  // List geometry
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = 5;
  localparam int WORD_W   = 32;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  // Command codes
  localparam logic [2:0] FN_APPEND  = 3'd0;
  localparam logic [2:0] FN_INSERT  = 3'd1;
  localparam logic [2:0] FN_REMOVE  = 3'd2;
  localparam logic [2:0] FN_READPOS = 3'd3;
  localparam logic [2:0] FN_READLST = 3'd4;
  localparam logic [2:0] FN_CLEAR   = 3'd5;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // Controller states
  typedef enum logic {
    S_IDLE,
    S_COMPACT
  } state_t;

  // What the cell row does this cycle
  typedef enum logic [1:0] {
    CM_HOLD,
    CM_WRITE,
    CM_INSERT,
    CM_COMPACT
  } cell_mode_t;

  // Broadcast to every cell
  typedef struct packed {
    cell_mode_t mode;
    word_t      value;
    cnt_t       tgt;
  } cell_ctl_t;

  // Per-cell position flags, derived from the target and the count
  typedef struct packed {
    logic sel;    // this cell is the target position
    logic above;  // this cell lies above the target position
    logic live;   // this cell holds a list entry
  } cell_pos_t;

endpackage

### design/olir_cmd_if.sv
// Command channel: valid/ready handshake with func, value and position.
// Depends on olir_pkg.
interface olir_cmd_if;
  logic              valid;
  logic              ready;
  logic [2:0]        func;
  olir_pkg::word_t   value;
  logic [4:0]        position;

  modport source (output valid, output func, output value, output position, input ready);
  modport sink   (input valid, input func, input value, input position, output ready);
endinterface

### design/olir_res_if.sv
// Result channel: valid/ready handshake with the read value and list status.
// Depends on olir_pkg.
interface olir_res_if;
  logic              valid;
  logic              ready;
  olir_pkg::word_t   read_value;
  logic [4:0]        length;
  logic              empty_res;
  logic              full_res;
  logic [4:0]        removed_count;
  logic [1:0]        status;

  modport source (output valid, output read_value, output length, output empty_res,
                  output full_res, output removed_count, output status, input ready);
  modport sink   (input valid, input read_value, input length, input empty_res,
                  input full_res, input removed_count, input status, output ready);
endinterface

### design/olir_cell.sv
// One list cell: holds one entry, loads from itself, the command, or a neighbor.
// Depends on olir_pkg.
module olir_cell (
  input  logic                clk,
  input  olir_pkg::cell_ctl_t ctl,
  input  olir_pkg::cell_pos_t pos,
  input  olir_pkg::word_t     prev_data,
  input  olir_pkg::word_t     next_data,
  input  logic                match_in,
  output logic                match_out,
  output olir_pkg::word_t     data
);

  logic match_here;

  // Match chain: every cell at or above the lowest live match closes up by one
  always_comb begin
    match_here = pos.live && (data == ctl.value);
    match_out  = match_in || match_here;
  end

  // Entry register
  always_ff @(posedge clk) begin
    unique case (ctl.mode)
      olir_pkg::CM_WRITE: begin
        if (pos.sel) data <= ctl.value;
      end
      olir_pkg::CM_INSERT: begin
        if (pos.sel)        data <= ctl.value;
        else if (pos.above) data <= prev_data;
      end
      olir_pkg::CM_COMPACT: begin
        if (match_out) data <= next_data;
      end
      olir_pkg::CM_HOLD: begin
      end
    endcase
  end

endmodule

### design/olir_ctrl.sv
// Command sequencer: count, status checks, read mux, compaction loop, result register.
// Depends on olir_pkg, olir_cmd_if, olir_res_if.
module olir_ctrl (
  input  logic                clk,
  input  logic                rst,
  olir_cmd_if.sink            cmd,
  olir_res_if.source          res,
  input  olir_pkg::word_t     cell_data [olir_pkg::CAPACITY],
  input  logic                any_match,
  output olir_pkg::cell_ctl_t ctl,
  output olir_pkg::cnt_t      count
);

  olir_pkg::state_t state, state_next;
  olir_pkg::cnt_t   count_next;
  olir_pkg::cnt_t   removed, removed_next;
  olir_pkg::cnt_t   last_idx;
  olir_pkg::word_t  rem_value;
  olir_pkg::word_t  rd_next;
  logic [1:0]       status_next;
  logic             res_load;
  logic             res_valid;
  logic             cmd_xfer;

  // Handshake: take a command only when idle and the result slot is free or emptying
  assign cmd.ready = (state == olir_pkg::S_IDLE) && (!res_valid || res.ready);
  assign cmd_xfer  = cmd.valid && cmd.ready;
  assign res.valid = res_valid;
  assign last_idx  = count - olir_pkg::cnt_t'(1);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      olir_pkg::S_IDLE: begin
        if (cmd_xfer && cmd.func == olir_pkg::FN_REMOVE) state_next = olir_pkg::S_COMPACT;
      end
      olir_pkg::S_COMPACT: begin
        if (!any_match) state_next = olir_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs: cell control, count update, result fields
  always_comb begin
    ctl.mode     = olir_pkg::CM_HOLD;
    ctl.value    = cmd.value;
    ctl.tgt      = cmd.position;
    count_next   = count;
    removed_next = removed;
    rd_next      = '0;
    status_next  = olir_pkg::ST_OK;
    res_load     = 1'b0;
    unique case (state)
      olir_pkg::S_IDLE: begin
        if (cmd_xfer) begin
          removed_next = '0;
          res_load     = (cmd.func != olir_pkg::FN_REMOVE);
          unique case (cmd.func)
            olir_pkg::FN_APPEND: begin
              if (count == olir_pkg::cnt_t'(olir_pkg::CAPACITY)) begin
                status_next = olir_pkg::ST_FULL;
              end else begin
                ctl.mode   = olir_pkg::CM_WRITE;
                ctl.tgt    = count;
                count_next = count + olir_pkg::cnt_t'(1);
              end
            end
            olir_pkg::FN_INSERT: begin
              if (count == olir_pkg::cnt_t'(olir_pkg::CAPACITY)) begin
                status_next = olir_pkg::ST_FULL;
              end else if (cmd.position > count) begin
                status_next = olir_pkg::ST_RANGE;
              end else begin
                ctl.mode   = olir_pkg::CM_INSERT;
                count_next = count + olir_pkg::cnt_t'(1);
              end
            end
            olir_pkg::FN_READPOS: begin
              if (count == '0)                 status_next = olir_pkg::ST_EMPTY;
              else if (cmd.position >= count)  status_next = olir_pkg::ST_RANGE;
              else rd_next = cell_data[cmd.position[olir_pkg::IDX_W-1:0]];
            end
            olir_pkg::FN_READLST: begin
              if (count == '0) status_next = olir_pkg::ST_EMPTY;
              else             rd_next = cell_data[last_idx[olir_pkg::IDX_W-1:0]];
            end
            olir_pkg::FN_CLEAR: begin
              count_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      olir_pkg::S_COMPACT: begin
        // Drop the lowest matching entry each cycle until none is left
        ctl.mode  = olir_pkg::CM_COMPACT;
        ctl.value = rem_value;
        if (any_match) begin
          count_next   = count - olir_pkg::cnt_t'(1);
          removed_next = removed + olir_pkg::cnt_t'(1);
        end else begin
          res_load = 1'b1;
        end
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= olir_pkg::S_IDLE;
      count     <= '0;
      removed   <= '0;
      res_valid <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      removed <= removed_next;
      if (res_load)       res_valid <= 1'b1;
      else if (res.ready) res_valid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd_xfer) rem_value <= cmd.value;
    if (res_load) begin
      res.read_value    <= rd_next;
      res.length        <= count_next;
      res.empty_res     <= (count_next == '0);
      res.full_res      <= (count_next == olir_pkg::cnt_t'(olir_pkg::CAPACITY));
      res.removed_count <= removed_next;
      res.status        <= status_next;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= olir_pkg::cnt_t'(olir_pkg::CAPACITY))
    else $error("list count beyond capacity");

  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    state == olir_pkg::S_COMPACT |-> !res_valid)
    else $error("result slot busy during compaction");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.ready |-> state == olir_pkg::S_IDLE)
    else $error("command taken outside idle");

  a_compact_step: assert property (@(posedge clk) disable iff (rst)
    state == olir_pkg::S_COMPACT && any_match
      |=> count == olir_pkg::cnt_t'($past(count) - olir_pkg::cnt_t'(1)))
    else $error("compaction step did not shorten the list");

endmodule

### design/ordered_list_insert_remove_core.sv
// Ordered list insert/remove core: a row of entry cells under one sequencer.
// Depends on olir_pkg, olir_cmd_if, olir_res_if, olir_cell, olir_ctrl.
//
//   Channel | Dir | Payload
//   cmd     | in  | func[2:0], value[31:0] signed, position[4:0]
//   res     | out | read_value[31:0] signed, length[4:0], empty_res, full_res,
//           |     | removed_count[4:0], status[1:0]
//
// Append, insert, reads, clear and unused codes: the result is registered in the
// cycle after the command transfer; insert moves the cells up in that same cycle.
// Remove enters compaction: the cell row closes up one match per cycle through its
// match chain, and the result is registered once no match is left.
// A new command transfers once idle and the result register is empty or being taken.
// rst is synchronous: list empty, result register empty; cell contents are not reset.
module ordered_list_insert_remove_core (
  input  logic       clk,
  input  logic       rst,
  olir_cmd_if.sink   cmd,
  olir_res_if.source res
);

  olir_pkg::cell_ctl_t ctl;
  olir_pkg::cnt_t      count;
  olir_pkg::word_t     cell_data [olir_pkg::CAPACITY];
  olir_pkg::cell_pos_t cell_pos  [olir_pkg::CAPACITY];
  logic [olir_pkg::CAPACITY:0] match_chain;

  assign match_chain[0] = 1'b0;

  olir_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .res       (res),
    .cell_data (cell_data),
    .any_match (match_chain[olir_pkg::CAPACITY]),
    .ctl       (ctl),
    .count     (count)
  );

  // Cell row
  for (genvar i = 0; i < olir_pkg::CAPACITY; i++) begin : g_cell
    olir_pkg::word_t prev_d, next_d;

    assign cell_pos[i].sel   = (ctl.tgt == olir_pkg::cnt_t'(i));
    assign cell_pos[i].above = (olir_pkg::cnt_t'(i) > ctl.tgt);
    assign cell_pos[i].live  = (olir_pkg::cnt_t'(i) < count);

    if (i == 0) begin : g_first
      assign prev_d = cell_data[i];
    end else begin : g_prev
      assign prev_d = cell_data[i-1];
    end

    if (i == olir_pkg::CAPACITY - 1) begin : g_last
      assign next_d = cell_data[i];
    end else begin : g_next
      assign next_d = cell_data[i+1];
    end

    olir_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .pos       (cell_pos[i]),
      .prev_data (prev_d),
      .next_data (next_d),
      .match_in  (match_chain[i]),
      .match_out (match_chain[i+1]),
      .data      (cell_data[i])
    );
  end

endmodule
